// ===== hw/rtl/uv_sphere_vertex_generator_top_macros.svh =====
// Assertion macros for the UV sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define USVG_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("usvg assertion failed");
`define USVG_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("usvg assertion failed");
`else
`define USVG_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons)
`define USVG_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)
`endif
`endif

// ===== hw/rtl/usvg_pkg.sv =====
// Shared types, constants and functions of the UV sphere vertex generator
`default_nettype none
package usvg_pkg;

    localparam int MAX_RINGS      = 256;
    localparam int MAX_SECTORS    = 256;
    localparam int CORDIC_STEPS   = 20;
    localparam int CORDIC_STEP_W  = $clog2(CORDIC_STEPS);
    localparam int DIV_CELLS      = 19;
    localparam int XW             = 34;
    localparam int ZW             = 33;
    localparam int PIPE_STAGES    = 1 + DIV_CELLS + 1 + CORDIC_STEPS + 4;

    localparam logic [30:0] PI2_Q30         = 31'h6487ED51;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

    localparam logic [15:0] RADIUS_RST = 16'd256;
    localparam logic [8:0]  COUNT_RST  = 9'd16;

    typedef enum logic [1:0] {
        CFG_RADIUS       = 2'd0,
        CFG_RING_COUNT   = 2'd1,
        CFG_SECTOR_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] base_index;
        logic        has_quad;
        logic        bad_index;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
    } side_t;

    typedef struct packed {
        logic [7:0]  rem;
        logic [7:0]  den;
        logic [19:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t lane_s;
        div_lane_t lane_r;
        side_t     side;
    } div_data_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [ZW-1:0] z;
        logic [1:0]    quad;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t phi;
        cordic_lane_t th;
        side_t        side;
    } cordic_data_t;

    function automatic logic [31:0] atan_q30(input logic [CORDIC_STEP_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h3243F6A8;
            5'd1:    a = 32'h1DAC6705;
            5'd2:    a = 32'h0FADBAFC;
            5'd3:    a = 32'h07F56EA6;
            5'd4:    a = 32'h03FEAB76;
            5'd5:    a = 32'h01FFD55B;
            5'd6:    a = 32'h00FFFAAA;
            5'd7:    a = 32'h007FFF55;
            5'd8:    a = 32'h003FFFEA;
            5'd9:    a = 32'h001FFFFD;
            5'd10:   a = 32'h000FFFFF;
            5'd11:   a = 32'h0007FFFF;
            5'd12:   a = 32'h0003FFFF;
            5'd13:   a = 32'h0001FFFF;
            5'd14:   a = 32'h0000FFFF;
            5'd15:   a = 32'h00007FFF;
            5'd16:   a = 32'h00003FFF;
            5'd17:   a = 32'h00001FFF;
            5'd18:   a = 32'h00000FFF;
            5'd19:   a = 32'h000007FF;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

    // divide by 2^n, rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned n);
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] q;
        half = 64'd1 << (n - 1);
        mag  = v[63] ? 64'(-v) : 64'(v);
        q    = (mag + half) >> n;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/usvg_div_cell.sv =====
// One restoring-division cell: one quotient bit per lane, registered
`default_nettype none
module usvg_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  usvg_pkg::div_data_t in_data,
    output logic                out_valid,
    output usvg_pkg::div_data_t out_data
);
    import usvg_pkg::*;

    logic      valid_reg;
    div_data_t data_reg;
    div_data_t data_next;

    function automatic div_lane_t div_step(input div_lane_t l);
        logic [8:0] t;
        logic [8:0] diff;
        logic       ge;
        div_lane_t  r;
        t    = {l.rem, 1'b0};
        diff = t - {1'b0, l.den};
        ge   = (t >= {1'b0, l.den});
        r     = l;
        r.rem = ge ? diff[7:0] : t[7:0];
        r.quo = {l.quo[18:0], ge};
        return r;
    endfunction

    always_comb
    begin
        data_next        = in_data;
        data_next.lane_s = div_step(in_data.lane_s);
        data_next.lane_r = div_step(in_data.lane_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/usvg_cordic_cell.sv =====
// One rotation CORDIC cell for the azimuth and polar lanes, registered
`default_nettype none
module usvg_cordic_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [usvg_pkg::CORDIC_STEP_W-1:0] step,
    input  logic                              in_valid,
    input  usvg_pkg::cordic_data_t            in_data,
    output logic                              out_valid,
    output usvg_pkg::cordic_data_t            out_data
);
    import usvg_pkg::*;

    logic         valid_reg;
    cordic_data_t data_reg;
    cordic_data_t data_next;

    function automatic cordic_lane_t rotate(input cordic_lane_t l,
                                            input logic [CORDIC_STEP_W-1:0] s);
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] z;
        logic signed [ZW-1:0] a;
        cordic_lane_t         r;
        x  = $signed(l.x);
        y  = $signed(l.y);
        z  = $signed(l.z);
        dx = y >>> s;
        dy = x >>> s;
        a  = $signed({1'b0, atan_q30(s)});
        r  = l;
        if (!z[ZW-1])
        begin
            r.x = x - dx;
            r.y = y + dy;
            r.z = z - a;
        end
        else
        begin
            r.x = x + dx;
            r.y = y - dy;
            r.z = z + a;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next     = in_data;
        data_next.phi = rotate(in_data.phi, step);
        data_next.th  = rotate(in_data.th, step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_generator_top.sv =====
// Top level of the UV sphere vertex generator: cell chains and output stages
//
//  channel   handshake             payload
//  input     start, busy           ring_index, sector_index
//  result    done (one cycle)      pos_*, normal_*, tex_u, tex_v, base_index,
//                                  has_quad, bad_index
//  config    cfg_we                cfg_index, cfg_wdata
//
// A new grid point is taken every cycle; busy is always low.
// The pipeline runs through an input stage, 19 division cells, a phase stage,
// 20 CORDIC cells and four multiply/round stages.
// Reset clears the valid chain and loads the register defaults.
// The receiver cannot stall; each result shows for one cycle with done.
`default_nettype none
`include "uv_sphere_vertex_generator_top_macros.svh"
module uv_sphere_vertex_generator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         ring_index,
    input  logic [7:0]         sector_index,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output logic               done,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [15:0]        base_index,
    output logic               has_quad,
    output logic               bad_index
);
    import usvg_pkg::*;

    // configuration
    logic [15:0] radius_reg;
    logic [8:0]  ring_count_reg;
    logic [8:0]  sector_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg       <= RADIUS_RST;
            ring_count_reg   <= COUNT_RST;
            sector_count_reg <= COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS:       radius_reg       <= cfg_wdata;
                CFG_RING_COUNT:   ring_count_reg   <= cfg_wdata[8:0];
                CFG_SECTOR_COUNT: sector_count_reg <= cfg_wdata[8:0];
                default:          ;
            endcase
        end
    end

    function automatic logic [8:0] clamp_count(input logic [8:0] v, input logic [8:0] mx);
        logic [8:0] r;
        if (v < 9'd2)
            r = 9'd2;
        else if (v > mx)
            r = mx;
        else
            r = v;
        return r;
    endfunction

    // input stage
    logic        accept;
    logic [8:0]  rings_c;
    logic [8:0]  secs_c;
    logic [8:0]  den_r9;
    logic [8:0]  den_s9;
    logic        bad;
    logic [7:0]  num_r;
    logic [7:0]  num_s;
    logic        top_r;
    logic        top_s;
    logic [16:0] base_full;
    logic        s0_valid_reg;
    div_data_t   s0_data_reg;
    div_data_t   s0_data_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        rings_c   = clamp_count(ring_count_reg, 9'(MAX_RINGS));
        secs_c    = clamp_count(sector_count_reg, 9'(MAX_SECTORS));
        den_r9    = rings_c - 9'd1;
        den_s9    = secs_c - 9'd1;
        bad       = ({1'b0, ring_index} >= rings_c) || ({1'b0, sector_index} >= secs_c);
        num_r     = bad ? 8'd0 : ring_index;
        num_s     = bad ? 8'd0 : sector_index;
        top_r     = (num_r == den_r9[7:0]);
        top_s     = (num_s == den_s9[7:0]);
        base_full = 17'(ring_index) * 17'(secs_c) + 17'(sector_index);

        s0_data_next                 = '0;
        s0_data_next.lane_s.den      = den_s9[7:0];
        s0_data_next.lane_s.rem      = top_s ? 8'd0 : num_s;
        s0_data_next.lane_s.quo      = {19'd0, top_s};
        s0_data_next.lane_r.den      = den_r9[7:0];
        s0_data_next.lane_r.rem      = top_r ? 8'd0 : num_r;
        s0_data_next.lane_r.quo      = {19'd0, top_r};
        s0_data_next.side.base_index = base_full[15:0];
        s0_data_next.side.has_quad   = ({1'b0, ring_index} < den_r9) &&
                                       ({1'b0, sector_index} < den_s9);
        s0_data_next.side.bad_index  = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_data_reg <= s0_data_next;
    end

    // division chain
    logic      div_valid [DIV_CELLS+1];
    div_data_t div_data  [DIV_CELLS+1];

    assign div_valid[0] = s0_valid_reg;
    assign div_data[0]  = s0_data_reg;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        usvg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // phase stage
    div_data_t    dq;
    logic [20:0]  az_full;
    logic [19:0]  pol_full;
    logic [17:0]  tu_full;
    logic [17:0]  tv_full;
    logic [17:0]  az_ph;
    logic [17:0]  pol_ph;
    logic [47:0]  zp_phi;
    logic [47:0]  zp_th;
    logic         ph_valid_reg;
    cordic_data_t ph_data_reg;
    cordic_data_t ph_data_next;

    always_comb
    begin
        dq       = div_data[DIV_CELLS];
        az_full  = {1'b0, dq.lane_s.quo} + 21'd1;
        pol_full = {1'b0, dq.lane_r.quo[19:1]} + 20'd1;
        tu_full  = {1'b0, dq.lane_s.quo[19:3]} + 18'd1;
        tv_full  = {1'b0, dq.lane_r.quo[19:3]} + 18'd1;
        az_ph    = az_full[18:1];
        pol_ph   = pol_full[18:1];
        zp_phi   = 48'(az_ph[15:0]) * 48'(PI2_Q30) + 48'd32768;
        zp_th    = 48'(pol_ph[15:0]) * 48'(PI2_Q30) + 48'd32768;

        ph_data_next            = '0;
        ph_data_next.side       = dq.side;
        ph_data_next.side.tex_u = tu_full[16:1];
        ph_data_next.side.tex_v = tv_full[16:1];
        ph_data_next.phi.x      = XW'(CORDIC_GAIN_Q30);
        ph_data_next.phi.z      = {1'b0, zp_phi[47:16]};
        ph_data_next.phi.quad   = az_ph[17:16];
        ph_data_next.th.x       = XW'(CORDIC_GAIN_Q30);
        ph_data_next.th.z       = {1'b0, zp_th[47:16]};
        ph_data_next.th.quad    = pol_ph[17:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_valid_reg <= 1'b0;
        end
        else
        begin
            ph_valid_reg <= div_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        ph_data_reg <= ph_data_next;
    end

    // CORDIC chain
    logic         cor_valid [CORDIC_STEPS+1];
    cordic_data_t cor_data  [CORDIC_STEPS+1];

    assign cor_valid[0] = ph_valid_reg;
    assign cor_data[0]  = ph_data_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        usvg_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (CORDIC_STEP_W'(i)),
            .in_valid  (cor_valid[i]),
            .in_data   (cor_data[i]),
            .out_valid (cor_valid[i+1]),
            .out_data  (cor_data[i+1])
        );
    end

    // quadrant fold and angle products
    function automatic logic signed [31:0] quad_cos(input cordic_lane_t l);
        logic signed [XW-1:0] r;
        case (l.quad)
            2'd0:    r = $signed(l.x);
            2'd1:    r = -$signed(l.y);
            2'd2:    r = -$signed(l.x);
            default: r = $signed(l.y);
        endcase
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] quad_sin(input cordic_lane_t l);
        logic signed [XW-1:0] r;
        case (l.quad)
            2'd0:    r = $signed(l.y);
            2'd1:    r = $signed(l.x);
            2'd2:    r = -$signed(l.y);
            default: r = -$signed(l.x);
        endcase
        return r[31:0];
    endfunction

    cordic_data_t       cq;
    logic signed [31:0] cphi;
    logic signed [31:0] sphi;
    logic signed [31:0] cth;
    logic signed [31:0] sth;
    logic               m1_valid_reg;
    side_t              m1_side_reg;
    logic signed [63:0] m1_px_reg;
    logic signed [63:0] m1_pz_reg;
    logic signed [31:0] m1_ny_reg;
    logic signed [63:0] m1_px_next;
    logic signed [63:0] m1_pz_next;
    logic signed [31:0] m1_ny_next;

    always_comb
    begin
        cq         = cor_data[CORDIC_STEPS];
        cphi       = quad_cos(cq.phi);
        sphi       = quad_sin(cq.phi);
        cth        = quad_cos(cq.th);
        sth        = quad_sin(cq.th);
        m1_px_next = 64'(cphi) * 64'(sth);
        m1_pz_next = 64'(sphi) * 64'(sth);
        m1_ny_next = -cth;
    end

    // normal vector in Q30
    logic               m2_valid_reg;
    side_t              m2_side_reg;
    logic signed [31:0] m2_nx_reg;
    logic signed [31:0] m2_ny_reg;
    logic signed [31:0] m2_nz_reg;
    logic signed [63:0] m2_nx_full;
    logic signed [63:0] m2_nz_full;

    assign m2_nx_full = rnd_shift(m1_px_reg, 30);
    assign m2_nz_full = rnd_shift(m1_pz_reg, 30);

    // radius products and normal rounding
    function automatic logic signed [15:0] sat_normal(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > 64'sd16384)
            r = 64'sd16384;
        else if (v < -64'sd16384)
            r = -64'sd16384;
        else
            r = v;
        return r[15:0];
    endfunction

    function automatic logic signed [16:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > 64'sd65535)
            r = 64'sd65535;
        else if (v < -64'sd65535)
            r = -64'sd65535;
        else
            r = v;
        return r[16:0];
    endfunction

    logic               m3_valid_reg;
    side_t              m3_side_reg;
    logic signed [48:0] m3_px_reg;
    logic signed [48:0] m3_py_reg;
    logic signed [48:0] m3_pz_reg;
    logic signed [15:0] m3_nx_reg;
    logic signed [15:0] m3_ny_reg;
    logic signed [15:0] m3_nz_reg;
    logic signed [48:0] rad_s;

    assign rad_s = 49'($signed({1'b0, radius_reg}));

    // output stage
    logic               done_reg;
    logic signed [16:0] pos_x_reg;
    logic signed [16:0] pos_y_reg;
    logic signed [16:0] pos_z_reg;
    logic signed [15:0] normal_x_reg;
    logic signed [15:0] normal_y_reg;
    logic signed [15:0] normal_z_reg;
    side_t              out_side_reg;
    side_t              out_side_next;
    logic               keep;

    always_comb
    begin
        keep          = !m3_side_reg.bad_index;
        out_side_next = keep ? m3_side_reg : '0;
        out_side_next.bad_index = m3_side_reg.bad_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= cor_valid[CORDIC_STEPS];
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            done_reg     <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_side_reg  <= cq.side;
        m1_px_reg    <= m1_px_next;
        m1_pz_reg    <= m1_pz_next;
        m1_ny_reg    <= m1_ny_next;

        m2_side_reg  <= m1_side_reg;
        m2_nx_reg    <= m2_nx_full[31:0];
        m2_ny_reg    <= m1_ny_reg;
        m2_nz_reg    <= m2_nz_full[31:0];

        m3_side_reg  <= m2_side_reg;
        m3_px_reg    <= 49'(m2_nx_reg) * rad_s;
        m3_py_reg    <= 49'(m2_ny_reg) * rad_s;
        m3_pz_reg    <= 49'(m2_nz_reg) * rad_s;
        m3_nx_reg    <= sat_normal(rnd_shift(64'(m2_nx_reg), 16));
        m3_ny_reg    <= sat_normal(rnd_shift(64'(m2_ny_reg), 16));
        m3_nz_reg    <= sat_normal(rnd_shift(64'(m2_nz_reg), 16));

        out_side_reg <= out_side_next;
        pos_x_reg    <= keep ? sat_pos(rnd_shift(64'(m3_px_reg), 30)) : '0;
        pos_y_reg    <= keep ? sat_pos(rnd_shift(64'(m3_py_reg), 30)) : '0;
        pos_z_reg    <= keep ? sat_pos(rnd_shift(64'(m3_pz_reg), 30)) : '0;
        normal_x_reg <= keep ? m3_nx_reg : '0;
        normal_y_reg <= keep ? m3_ny_reg : '0;
        normal_z_reg <= keep ? m3_nz_reg : '0;
    end

    assign done       = done_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign normal_x   = normal_x_reg;
    assign normal_y   = normal_y_reg;
    assign normal_z   = normal_z_reg;
    assign tex_u      = out_side_reg.tex_u;
    assign tex_v      = out_side_reg.tex_v;
    assign base_index = out_side_reg.base_index;
    assign has_quad   = out_side_reg.has_quad;
    assign bad_index  = out_side_reg.bad_index;

    `USVG_ASSERT_IMP(a_latency, clk, rst_n, done, $past(accept, PIPE_STAGES))
    `USVG_ASSERT_IMP(a_bad_zero, clk, rst_n, done && bad_index, pos_x == 0 && pos_y == 0 && pos_z == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0 && tex_u == 0 && tex_v == 0 && base_index == 0 && !has_quad)
    `USVG_ASSERT_IMP(a_tex_range, clk, rst_n, done, tex_u <= 16'd32768 && tex_v <= 16'd32768)
    `USVG_ASSERT_NEXT(a_div_handoff, clk, rst_n, s0_valid_reg, div_valid[1])

endmodule
`default_nettype wire

// ===== dv/uv_sphere_vertex_generator_top_tb.sv =====
// Self-checking testbench for the UV sphere vertex generator top level
`timescale 1ns / 100ps
`default_nettype none
module uv_sphere_vertex_generator_top_tb;
    import usvg_pkg::*;

    typedef struct {
        logic signed [16:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic [15:0]        tu, tv, base;
        logic               quad, bad;
    } vertex_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint floor_sh(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint round_sh(input longint v, input int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0)
            return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint ratio(input longint num, input longint scale, input longint den);
        return (2 * num * scale + den) / (2 * den);
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl [20] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
            'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
            'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
            'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF};
        return tbl[i];
    endfunction

    task automatic rotate(input longint phase, output longint c, output longint s);
        longint r, z, x, y, dx, dy;
        int q;
        q = int'((phase >> 16) & 3);
        r = phase & 'hFFFF;
        z = (r * 'h6487ED51 + 32768) >>> 16;
        x = 'h26DD3B6A;
        y = 0;
        for (int i = 0; i < 20; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    class vertex_scoreboard;
        longint radius_q = 256, rings_q = 16, sectors_q = 16;
        vertex_t pending[$];
        int transfers = 0;

        function automatic longint clamp_cnt(input longint v);
            return v < 2 ? 2 : (v > 256 ? 256 : v);
        endfunction

        function void note_write(input cfg_reg_t idx, input logic [15:0] val);
            case (idx)
                CFG_RADIUS:       radius_q = longint'(val);
                CFG_RING_COUNT:   rings_q = longint'(val[8:0]);
                CFG_SECTOR_COUNT: sectors_q = longint'(val[8:0]);
                default: ;
            endcase
        endfunction

        task note_input(input logic [7:0] ring, input logic [7:0] sec);
            vertex_t e;
            longint nr, ns, cp, sp, ct, st;
            longint rl, sl;
            longint n [3];
            nr = clamp_cnt(rings_q);
            ns = clamp_cnt(sectors_q);
            rl = longint'(ring);
            sl = longint'(sec);
            e = '{default: 0};
            if (rl >= nr || sl >= ns)
                e.bad = 1'b1;
            else
            begin
                rotate(ratio(sl, 1 << 18, ns - 1) & 'h3FFFF, cp, sp);
                rotate(ratio(rl, 1 << 17, nr - 1) & 'h3FFFF, ct, st);
                n[0] = round_sh(cp * st, 30);
                n[1] = -ct;
                n[2] = round_sh(sp * st, 30);
                e.px = 17'(clip(round_sh(n[0] * radius_q, 30), 65535));
                e.py = 17'(clip(round_sh(n[1] * radius_q, 30), 65535));
                e.pz = 17'(clip(round_sh(n[2] * radius_q, 30), 65535));
                e.nx = 16'(clip(round_sh(n[0], 16), 16384));
                e.ny = 16'(clip(round_sh(n[1], 16), 16384));
                e.nz = 16'(clip(round_sh(n[2], 16), 16384));
                e.tu = 16'(ratio(sl, 32768, ns - 1));
                e.tv = 16'(ratio(rl, 32768, nr - 1));
                e.base = 16'(rl * ns + sl);
                e.quad = (rl < nr - 1) && (sl < ns - 1);
            end
            pending.push_back(e);
        endtask

        task check_result(input vertex_t g);
            vertex_t e;
            transfers++;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (g.px !== e.px) report_mismatch("pos_x", longint'(g.px), longint'(e.px));
            if (g.py !== e.py) report_mismatch("pos_y", longint'(g.py), longint'(e.py));
            if (g.pz !== e.pz) report_mismatch("pos_z", longint'(g.pz), longint'(e.pz));
            if (g.nx !== e.nx) report_mismatch("normal_x", longint'(g.nx), longint'(e.nx));
            if (g.ny !== e.ny) report_mismatch("normal_y", longint'(g.ny), longint'(e.ny));
            if (g.nz !== e.nz) report_mismatch("normal_z", longint'(g.nz), longint'(e.nz));
            if (g.tu !== e.tu) report_mismatch("tex_u", longint'(g.tu), longint'(e.tu));
            if (g.tv !== e.tv) report_mismatch("tex_v", longint'(g.tv), longint'(e.tv));
            if (g.base !== e.base)
                report_mismatch("base_index", longint'(g.base), longint'(e.base));
            if (g.quad !== e.quad)
                report_mismatch("has_quad", longint'(g.quad), longint'(e.quad));
            if (g.bad !== e.bad) report_mismatch("bad_index", longint'(g.bad), longint'(e.bad));
        endtask
    endclass

    logic clk = 0, rst_n = 0, start = 0, cfg_we = 0;
    logic [7:0] ring_index = 0, sector_index = 0;
    logic [1:0] cfg_index = 0;
    logic [15:0] cfg_wdata = 0;
    logic busy, done, has_quad, bad_index;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic [15:0] tex_u, tex_v, base_index;

    vertex_scoreboard sb = new();
    int idle_pct = 0;

    uv_sphere_vertex_generator_top dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        vertex_t g;
        if (rst_n && done)
        begin
            g = '{pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  tex_u, tex_v, base_index, has_quad, bad_index};
            sb.check_result(g);
        end
        if (rst_n && start && !busy)
            sb.note_input(ring_index, sector_index);
    end

    task automatic send_point(input logic [7:0] ring, input logic [7:0] sec);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 0;
        end
        @(negedge clk);
        start <= 1;
        ring_index <= ring;
        sector_index <= sec;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.note_write(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_sphere(input logic [15:0] rad, input logic [15:0] nr,
                              input logic [15:0] ns);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_RING_COUNT, nr);
        write_reg(CFG_SECTOR_COUNT, ns);
    endtask

    task automatic random_phase(input int count, input int pct);
        longint nr, ns;
        int rmax, smax;
        idle_pct = pct;
        nr = sb.clamp_cnt(sb.rings_q);
        ns = sb.clamp_cnt(sb.sectors_q);
        rmax = int'(nr - 1);
        smax = int'(ns - 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_point(8'($urandom), 8'($urandom));
            else
                send_point(8'($urandom_range(rmax)), 8'($urandom_range(smax)));
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: default sphere corners, poles, out of range
        send_point(0, 0);
        send_point(15, 15);
        send_point(7, 8);
        send_point(14, 14);
        send_point(16, 0);
        send_point(0, 16);
        send_point(255, 255);
        send_point(8, 4);
        drain();
        set_sphere(16'hFFFF, 16'h01FF, 16'h01FF);
        send_point(255, 255);
        send_point(128, 64);
        send_point(0, 255);
        send_point(170, 85);
        drain();
        set_sphere(0, 0, 1);
        send_point(0, 0);
        send_point(1, 1);
        send_point(2, 0);
        send_point(0, 2);
        drain();
        set_sphere(1, 2, 2);
        send_point(1, 1);
        send_point(0, 1);
        drain();
        set_sphere(16'h8000, 256, 256);
        random_phase(250, 0);
        set_sphere(16'($urandom), 16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)));
        random_phase(250, 65);
        set_sphere(16'($urandom), 16'($urandom_range(0, 511)), 16'($urandom_range(0, 511)));
        random_phase(250, 15);
        set_sphere(16'hFFFF, 3, 255);
        random_phase(150, 0);
        set_sphere(16'($urandom), 16'($urandom_range(2, 256)), 16'($urandom_range(2, 256)));
        random_phase(150, 65);
        $display("covered %0d vertex transfers over several sphere settings and idle mixes",
                 sb.transfers);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/usvg_pkg.sv
hw/rtl/usvg_div_cell.sv
hw/rtl/usvg_cordic_cell.sv
hw/rtl/uv_sphere_vertex_generator_top.sv
dv/uv_sphere_vertex_generator_top_tb.sv
